/* rtl/pss_pkg.sv */
// Shared types, constants and helper functions of the step sequencer.
package pss_pkg;

  // Default parameter values
  localparam int DEF_MAX_STEPS  = 16;
  localparam int DEF_PHASE_BITS = 16;

  // Fixed field widths
  localparam int BEAT_W     = 32;
  localparam int GSTEP_W    = 32;
  localparam int VALUE_W    = 15;
  localparam int LOAD_IDX_W = 4;
  localparam int STEP_IDX_W = 4;
  localparam int KIND_W     = 2;
  localparam int NOTE_W     = 7;
  localparam int RATE_W     = 6;
  localparam int SEED_CMP_W = 48;

  // Remainder unit: bits consumed per cycle
  localparam int REM_BITS = 8;

  // Configuration port
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REGSEL_W = 3;

  // Register widths and reset values
  localparam int SC_W   = 5;
  localparam int RS_W   = 4;
  localparam int GL_W   = 17;
  localparam int FP_W   = 17;
  localparam int CH_W   = 4;
  localparam logic [SC_W-1:0] RST_STEP_COUNT  = 5'd8;
  localparam logic [RS_W-1:0] RST_RATE_SELECT = 4'd2;
  localparam logic [GL_W-1:0] RST_GATE_LENGTH = 17'd52429;
  localparam logic [FP_W-1:0] RST_FIRE_PROB   = 17'd65536;
  localparam logic [CH_W-1:0] RST_MIDI_CHAN   = 4'd0;

  localparam int NOTE_MAX = 127;

  // Register indexes
  typedef enum logic [REGSEL_W-1:0] {
    REG_STEP_COUNT,
    REG_RATE_SELECT,
    REG_GATE_LENGTH,
    REG_FIRE_PROB,
    REG_MIDI_CHAN
  } reg_idx_t;

  // Item operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // MIDI event kinds
  typedef enum logic [KIND_W-1:0] {
    MIDI_NONE,
    MIDI_OFF,
    MIDI_ON
  } midi_kind_t;

  // Rate select codes
  localparam logic [RS_W-1:0] RATE_QUARTER = 4'd0;
  localparam logic [RS_W-1:0] RATE_HALF    = 4'd1;
  localparam logic [RS_W-1:0] RATE_ONE     = 4'd2;
  localparam logic [RS_W-1:0] RATE_TWO     = 4'd3;
  localparam logic [RS_W-1:0] RATE_FOUR    = 4'd4;
  localparam logic [RS_W-1:0] RATE_EIGHT   = 4'd5;
  localparam logic [RS_W-1:0] RATE_ONEHALF = 4'd6;
  localparam logic [RS_W-1:0] RATE_THREE   = 4'd7;

  // Request to the remainder unit
  typedef struct packed {
    logic               start;
    logic [GSTEP_W-1:0] dividend;
  } rem_req_t;

  // Steps per beat in quarters; codes above the table act as six
  function automatic logic [RATE_W-1:0] rate_quarters(input logic [RS_W-1:0] sel);
    logic [RATE_W-1:0] q;
    case (sel)
      RATE_QUARTER: q = 6'd1;
      RATE_HALF:    q = 6'd2;
      RATE_ONE:     q = 6'd4;
      RATE_TWO:     q = 6'd8;
      RATE_FOUR:    q = 6'd16;
      RATE_EIGHT:   q = 6'd32;
      RATE_ONEHALF: q = 6'd6;
      RATE_THREE:   q = 6'd12;
      default:      q = 6'd24;
    endcase
    return q;
  endfunction

  // xorshift32 hash of a global step
  function automatic logic [GSTEP_W-1:0] hash32(input logic [GSTEP_W-1:0] s);
    logic [GSTEP_W-1:0] h;
    h = s;
    h = h ^ (h << 13);
    h = h ^ (h >> 17);
    h = h ^ (h << 5);
    return h;
  endfunction

endpackage

/* rtl/pss_in_if.sv */
// Input channel of the step sequencer: phase ticks and step loads.
interface pss_in_if #(
  parameter int PHASE_BITS = pss_pkg::DEF_PHASE_BITS
);
  import pss_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [PHASE_BITS-1:0]        tick_phase;
  logic [LOAD_IDX_W-1:0]        load_index;
  logic signed [VALUE_W-1:0]    load_value;

  modport source (output valid, op, tick_phase, load_index, load_value, input ready);
  modport sink   (input valid, op, tick_phase, load_index, load_value, output ready);
endinterface

/* rtl/pss_out_if.sv */
// Result channel of the step sequencer.
interface pss_out_if;
  import pss_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] step_value_out;
  logic                      trigger;
  logic                      gate;
  logic [STEP_IDX_W-1:0]     step_index;
  logic [KIND_W-1:0]         midi_kind;
  logic [NOTE_W-1:0]         midi_note;
  logic                      last;

  modport source (output valid, step_value_out, trigger, gate, step_index, midi_kind,
                  midi_note, last, input ready);
  modport sink   (input valid, step_value_out, trigger, gate, step_index, midi_kind,
                  midi_note, last, output ready);
endinterface

/* rtl/probabilistic_step_sequencer.sv */
// Probabilistic step sequencer: phase ticks in, step value, gate and MIDI events out.
//
// Each tick item carries a beat phase; the block counts beat wraps, scales the
// beat position by the selected rate, takes the step index modulo the step
// count, looks the step value up in a table and decides by a hash of the global
// step whether the step fires. A tick passes through the multiply, hash,
// remainder, read, evaluate and send states to the output register, with an
// extra send state when a note-off precedes a note-on, and no new item is
// taken until the sequencer is back in idle. The remainder unit works through
// 8 dividend bits per cycle; the table read is registered. A load item writes the
// table in the cycle it is accepted and the next item can follow at once. The
// output register lets the block take the next item while a result still waits.
// The table reads as undefined until each entry has been loaded.
module probabilistic_step_sequencer #(
  parameter int MAX_STEPS  = pss_pkg::DEF_MAX_STEPS,
  parameter int PHASE_BITS = pss_pkg::DEF_PHASE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pss_in_if.sink                      in_ch,
  pss_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pss_pkg::PADDR_W-1:0] paddr,
  input  logic [pss_pkg::PDATA_W-1:0] pwdata,
  output logic [pss_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import pss_pkg::*;

  localparam int IDX_W  = $clog2(MAX_STEPS);
  localparam int NW     = $clog2(MAX_STEPS + 1);
  localparam int POS_W  = BEAT_W + PHASE_BITS;
  localparam int SCL_W  = POS_W + RATE_W;
  localparam int FRAC_W = PHASE_BITS + 2;
  localparam int GCMP_W = FRAC_W + GL_W;
  localparam logic [PHASE_BITS-1:0] HALF_BEAT = PHASE_BITS'(1) << (PHASE_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_HASH,
    S_MOD,
    S_READ,
    S_EVAL,
    S_SEND_OFF,
    S_SEND
  } state_t;

  // Configuration registers
  logic [SC_W-1:0] step_count_r;
  logic [RS_W-1:0] rate_sel_r;
  logic [GL_W-1:0] gate_len_r;
  logic [FP_W-1:0] fire_prob_r;
  logic [CH_W-1:0] midi_chan_r;
  logic            cfg_wr;

  // Control and sequencing state
  state_t                  state_r;
  logic [PHASE_BITS-1:0]   last_phase_r;
  logic [BEAT_W-1:0]       beat_cnt_r;
  logic [IDX_W-1:0]        last_step_r;
  logic                    last_step_vld_r;
  logic                    last_gate_r;
  logic [NOTE_W-1:0]       held_note_r;
  logic                    held_vld_r;

  // Datapath registers of one tick
  logic [POS_W-1:0]        pos_r;
  logic [RATE_W-1:0]       quarters_r;
  logic [NW-1:0]           n_r;
  logic [GSTEP_W-1:0]      gstep_r;
  logic [FRAC_W-1:0]       frac_r;
  logic [GSTEP_W-1:0]      seed_r;
  logic [SEED_CMP_W-1:0]   prob_rhs_r;
  logic                    gate_lt_r;
  logic                    fire_r;
  logic signed [VALUE_W-1:0] val_r;
  logic                    trig_r;
  logic                    gate_r;
  logic [STEP_IDX_W-1:0]   idx_r;
  midi_kind_t              kind_r;
  logic [NOTE_W-1:0]       note_r;
  logic [NOTE_W-1:0]       off_note_r;

  // Output register
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_val_r;
  logic                      out_trig_r;
  logic                      out_gate_r;
  logic [STEP_IDX_W-1:0]     out_idx_r;
  midi_kind_t                out_kind_r;
  logic [NOTE_W-1:0]         out_note_r;
  logic                      out_last_r;
  logic                      slot_free;

  // Combinational helpers
  logic                    in_acc;
  logic [PHASE_BITS-1:0]   phase_diff;
  logic                    wrap;
  logic [BEAT_W-1:0]       beat_cnt_nxt;
  logic [NW-1:0]           n_clamp;
  logic [SCL_W-1:0]        scaled;
  logic [GSTEP_W-1:0]      seed_src;
  logic [LOAD_IDX_W+IDX_W-1:0] li_ext;
  logic                    li_ok;
  logic [GCMP_W-1:0]       gate_lhs;
  logic [GCMP_W-1:0]       gate_rhs;

  // Table memory and remainder unit
  logic                    ram_we;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_waddr;
  logic [VALUE_W-1:0]      ram_rdata;
  rem_req_t                rem_req;
  logic                    rem_busy;
  logic [NW-1:0]           rem_q;

  // Evaluation of a tick
  logic signed [VALUE_W-1:0] ev_val;
  logic signed [VALUE_W-1:0] ev_outv;
  logic                      ev_gate;
  logic [IDX_W-1:0]          ev_cur;
  logic [IDX_W+STEP_IDX_W-1:0] ev_cur_ext;
  logic                      ev_new;
  logic [NOTE_W-1:0]         ev_note;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= RST_STEP_COUNT;
      rate_sel_r   <= RST_RATE_SELECT;
      gate_len_r   <= RST_GATE_LENGTH;
      fire_prob_r  <= RST_FIRE_PROB;
      midi_chan_r  <= RST_MIDI_CHAN;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:2])
        REG_STEP_COUNT:  step_count_r <= pwdata[SC_W-1:0];
        REG_RATE_SELECT: rate_sel_r   <= pwdata[RS_W-1:0];
        REG_GATE_LENGTH: gate_len_r   <= pwdata[GL_W-1:0];
        REG_FIRE_PROB:   fire_prob_r  <= pwdata[FP_W-1:0];
        REG_MIDI_CHAN:   midi_chan_r  <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_STEP_COUNT:  prdata = PDATA_W'(step_count_r);
      REG_RATE_SELECT: prdata = PDATA_W'(rate_sel_r);
      REG_GATE_LENGTH: prdata = PDATA_W'(gate_len_r);
      REG_FIRE_PROB:   prdata = PDATA_W'(fire_prob_r);
      REG_MIDI_CHAN:   prdata = PDATA_W'(midi_chan_r);
      default:         prdata = '0;
    endcase
  end

  // Accept, detect beat wrap, clamp step count
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && (state_r == S_IDLE);
  assign phase_diff   = last_phase_r - in_ch.tick_phase;
  assign wrap         = (last_phase_r > in_ch.tick_phase) && (phase_diff > HALF_BEAT);
  assign beat_cnt_nxt = beat_cnt_r + BEAT_W'(wrap);

  always_comb begin
    if (step_count_r == '0) begin
      n_clamp = NW'(1);
    end else if (32'(step_count_r) > MAX_STEPS) begin
      n_clamp = NW'(MAX_STEPS);
    end else begin
      n_clamp = NW'(step_count_r);
    end
  end

  // Table writes on load items inside the table range
  assign li_ext    = (LOAD_IDX_W+IDX_W)'(in_ch.load_index);
  assign li_ok     = (32'(li_ext) < MAX_STEPS);
  assign ram_waddr = li_ext[IDX_W-1:0];
  assign ram_we    = in_acc && (in_ch.op == OP_LOAD) && li_ok;
  assign ram_re    = (state_r == S_READ);

  pss_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_STEPS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.load_value),
    .re    (ram_re),
    .raddr (rem_q[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Scale, hash and gate compare
  assign scaled   = SCL_W'(pos_r) * SCL_W'(quarters_r);
  assign seed_src = (gstep_r == '0) ? GSTEP_W'(1) : gstep_r;
  assign gate_lhs = GCMP_W'({frac_r, 16'h0});
  assign gate_rhs = {gate_len_r, FRAC_W'(0)};

  assign rem_req.start    = (state_r == S_HASH);
  assign rem_req.dividend = gstep_r;

  pss_rem #(
    .NW (NW)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (rem_req),
    .divisor (n_r),
    .busy    (rem_busy),
    .rem     (rem_q)
  );

  // Step value, trigger, gate and note of the current tick
  assign ev_val     = $signed(ram_rdata);
  assign ev_outv    = fire_r ? ev_val : '0;
  assign ev_gate    = fire_r && gate_lt_r;
  assign ev_cur     = rem_q[IDX_W-1:0];
  assign ev_cur_ext = (IDX_W+STEP_IDX_W)'(ev_cur);
  assign ev_new     = !last_step_vld_r || (ev_cur != last_step_r);

  always_comb begin
    if (ev_outv[VALUE_W-1]) begin
      ev_note = '0;
    end else if (ev_outv[VALUE_W-2:0] > (VALUE_W-1)'(NOTE_MAX)) begin
      ev_note = NOTE_W'(NOTE_MAX);
    end else begin
      ev_note = ev_outv[NOTE_W-1:0];
    end
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  // Sequencer and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      last_phase_r    <= '0;
      beat_cnt_r      <= '0;
      last_step_r     <= '0;
      last_step_vld_r <= 1'b0;
      last_gate_r     <= 1'b0;
      held_note_r     <= '0;
      held_vld_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      // Drop a taken result unless a send state reloads the register
      if (out_ch.ready && (state_r != S_SEND) && (state_r != S_SEND_OFF)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && (in_ch.op == OP_TICK)) begin
            last_phase_r <= in_ch.tick_phase;
            beat_cnt_r   <= beat_cnt_nxt;
            pos_r        <= {beat_cnt_nxt, in_ch.tick_phase};
            quarters_r   <= rate_quarters(rate_sel_r);
            n_r          <= n_clamp;
            state_r      <= S_MUL;
          end
        end
        S_MUL: begin
          gstep_r <= scaled[FRAC_W +: GSTEP_W];
          frac_r  <= scaled[FRAC_W-1:0];
          state_r <= S_HASH;
        end
        S_HASH: begin
          seed_r     <= hash32(seed_src);
          prob_rhs_r <= {fire_prob_r[15:0], 32'h0} - SEED_CMP_W'(fire_prob_r[15:0]);
          gate_lt_r  <= gate_lhs < gate_rhs;
          state_r    <= S_MOD;
        end
        S_MOD: begin
          fire_r <= fire_prob_r[FP_W-1] || ({seed_r, 16'h0} < prob_rhs_r);
          if (!rem_busy) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          val_r           <= ev_outv;
          trig_r          <= ev_new && fire_r;
          gate_r          <= ev_gate;
          idx_r           <= ev_cur_ext[STEP_IDX_W-1:0];
          off_note_r      <= held_note_r;
          last_step_r     <= ev_cur;
          last_step_vld_r <= 1'b1;
          last_gate_r     <= ev_gate;
          state_r         <= S_SEND;
          if (ev_gate && !last_gate_r) begin
            kind_r      <= MIDI_ON;
            note_r      <= ev_note;
            held_note_r <= ev_note;
            held_vld_r  <= 1'b1;
            if (held_vld_r) begin
              state_r <= S_SEND_OFF;
            end
          end else if (!ev_gate && last_gate_r && held_vld_r) begin
            kind_r     <= MIDI_OFF;
            note_r     <= held_note_r;
            held_vld_r <= 1'b0;
          end else begin
            kind_r <= MIDI_NONE;
            note_r <= '0;
          end
        end
        S_SEND_OFF: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_val_r   <= val_r;
            out_trig_r  <= trig_r;
            out_gate_r  <= gate_r;
            out_idx_r   <= idx_r;
            out_kind_r  <= MIDI_OFF;
            out_note_r  <= off_note_r;
            out_last_r  <= 1'b0;
            state_r     <= S_SEND;
          end
        end
        S_SEND: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_val_r   <= val_r;
            out_trig_r  <= trig_r;
            out_gate_r  <= gate_r;
            out_idx_r   <= idx_r;
            out_kind_r  <= kind_r;
            out_note_r  <= note_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Drive the result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.step_value_out = out_val_r;
  assign out_ch.trigger        = out_trig_r;
  assign out_ch.gate           = out_gate_r;
  assign out_ch.step_index     = out_idx_r;
  assign out_ch.midi_kind      = out_kind_r;
  assign out_ch.midi_note      = out_note_r;
  assign out_ch.last           = out_last_r;

  // The remainder unit is idle whenever the sequencer waits for an item
  a_rem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !rem_busy)
    else $error("remainder unit busy while sequencer idle");

  // A held gate always has a note behind it
  a_gate_held: assert property (@(posedge clk) disable iff (!rst_n)
    last_gate_r |-> held_vld_r)
    else $error("gate high without a held note");

  // A non-final item is a note-off and is followed by the note-on of the same tick
  a_off_then_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r && out_ch.ready) |=>
      (out_valid_r && out_last_r && (out_kind_r == MIDI_ON)))
    else $error("note-off item not followed by note-on");

  // Table writes never meet a table read
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table write and read in the same cycle");

endmodule

/* rtl/pss_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* rtl/pss_rem.sv */
// Remainder unit: 32-bit dividend modulo a small divisor, several bits per cycle.
module pss_rem #(
  parameter int NW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pss_pkg::rem_req_t req,
  input  logic [NW-1:0]     divisor,
  output logic              busy,
  output logic [NW-1:0]     rem
);
  import pss_pkg::*;

  localparam int STEPS = GSTEP_W / REM_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0]   cnt_r;
  logic [GSTEP_W-1:0] sh_r;
  logic [NW-1:0]      rem_r;
  logic [NW-1:0]      rem_nxt;

  // One restoring step per dividend bit, REM_BITS steps this cycle
  always_comb begin
    logic [NW:0] t;
    rem_nxt = rem_r;
    for (int i = 0; i < REM_BITS; i++) begin
      t = {rem_nxt, sh_r[GSTEP_W-1-i]};
      if (t >= (NW+1)'(divisor)) begin
        t = t - (NW+1)'(divisor);
      end
      rem_nxt = t[NW-1:0];
    end
  end

  // Load on start, then advance until the dividend is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= CNT_W'(STEPS);
      sh_r  <= req.dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
      sh_r  <= sh_r << REM_BITS;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign rem  = rem_r;
endmodule

/* test/tb_probabilistic_step_sequencer.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the probabilistic step sequencer against a built-in predictor.
module tb_probabilistic_step_sequencer;
  import pss_pkg::*;

  localparam int STEPS          = DEF_MAX_STEPS;
  localparam int PB             = DEF_PHASE_BITS;
  localparam int HALF_BEAT      = 1 << (PB - 1);
  localparam int SETTLE_CYCLES  = 24;
  localparam int STALL_CYCLES   = 400;
  localparam int ITEMS_PER_SET  = 65;
  localparam int NUM_SETS       = 15;
  localparam int TIMEOUT_NS     = 5_000_000;
  localparam int VALUE_LIMIT    = 10000;

  // Rate codes without a name in the package: the top one and an out-of-range one
  localparam logic [RS_W-1:0] RATE_SIX  = 4'd8;
  localparam logic [RS_W-1:0] RATE_OVER = 4'd15;
  localparam logic [FP_W-1:0] PROB_ONE  = 17'd65536;
  localparam logic [GL_W-1:0] GATE_ONE  = 17'd65536;
  localparam logic [GL_W-1:0] GATE_MIN  = 17'd655;
  localparam logic [FP_W-1:0] Q16_TOP   = 17'h1FFFF;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      trig;
    logic                      gate;
    logic [STEP_IDX_W-1:0]     idx;
    midi_kind_t                kind;
    logic [NOTE_W-1:0]         note;
    logic                      last;
  } step_event_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  pss_in_if #(.PHASE_BITS(PB)) in_bus ();
  pss_out_if                   out_bus ();

  probabilistic_step_sequencer #(
    .MAX_STEPS (STEPS),
    .PHASE_BITS(PB)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor copy of the registers and the sequencer state
  logic [SC_W-1:0]           m_step_count;
  logic [RS_W-1:0]           m_rate;
  logic [GL_W-1:0]           m_gate_len;
  logic [FP_W-1:0]           m_fire_prob;
  logic [CH_W-1:0]           m_chan;
  logic signed [VALUE_W-1:0] m_table [STEPS];
  logic [PB-1:0]             m_last_phase;
  logic [BEAT_W-1:0]         m_beats;
  logic [STEP_IDX_W-1:0]     m_last_step;
  logic                      m_step_seen;
  logic                      m_last_gate;
  logic [NOTE_W-1:0]         m_held_note;
  logic                      m_holding;

  step_event_t expected_events [$];
  step_event_t want_ev;
  step_event_t got_ev;

  int          src_idle_pct;
  int          snk_idle_pct;
  int          stall_request;
  int          stall_left;
  int          mismatch_count;
  int          tick_count;
  int          load_count;
  int          result_count;
  int          setting_count;
  logic [PB-1:0] walk_phase;
  int unsigned walk_stride;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Steps per beat in quarters for a clamped rate code
  function automatic int unsigned steps_per_beat_q(input logic [RS_W-1:0] sel);
    case (sel)
      RATE_QUARTER: return 1;
      RATE_HALF:    return 2;
      RATE_ONE:     return 4;
      RATE_TWO:     return 8;
      RATE_FOUR:    return 16;
      RATE_EIGHT:   return 32;
      RATE_ONEHALF: return 6;
      RATE_THREE:   return 12;
      default:      return 24;
    endcase
  endfunction

  function automatic logic [GSTEP_W-1:0] xorshift32(input logic [GSTEP_W-1:0] s);
    logic [GSTEP_W-1:0] h;
    h = s ^ (s << 13);
    h = h ^ (h >> 17);
    h = h ^ (h << 5);
    return h;
  endfunction

  // Advance the predicted state by one tick and queue the items it yields
  function automatic void predict_tick(input logic [PB-1:0] phase);
    logic [63:0]               scaled;
    logic [63:0]               frac;
    logic [GSTEP_W-1:0]        gstep;
    logic [GSTEP_W-1:0]        seed;
    logic [RS_W-1:0]           rsel;
    int unsigned               n;
    logic [STEP_IDX_W-1:0]     cur;
    logic signed [VALUE_W-1:0] outv;
    logic                      fires;
    logic                      fresh;
    logic                      gate_now;
    logic [NOTE_W-1:0]         note;
    step_event_t               ev;
    if (int'(m_last_phase) - int'(phase) > HALF_BEAT) m_beats = m_beats + 1'b1;
    m_last_phase = phase;

    n = (m_step_count == 0) ? 1 : ((m_step_count > STEPS) ? STEPS : m_step_count);
    rsel = (m_rate > RATE_SIX) ? RATE_SIX : m_rate;

    scaled = ({32'd0, m_beats} << PB) | {48'd0, phase};
    scaled = scaled * steps_per_beat_q(rsel);
    gstep  = scaled[PB+2 +: GSTEP_W];
    frac   = scaled & ((64'd1 << (PB + 2)) - 1);
    cur    = STEP_IDX_W'(gstep % n);

    fresh = !m_step_seen || (cur != m_last_step);
    m_last_step = cur;
    m_step_seen = 1'b1;

    // Hash the global step, zero counting as one
    fires = 1'b1;
    if (m_fire_prob < PROB_ONE) begin
      seed  = xorshift32((gstep == 0) ? 32'd1 : gstep);
      fires = ({32'd0, seed} << 16) < ({47'd0, m_fire_prob} * 64'hFFFF_FFFF);
    end

    outv     = fires ? m_table[cur] : '0;
    gate_now = fires && ((frac << 16) < ({47'd0, m_gate_len} << (PB + 2)));
    if (outv < 0) note = '0;
    else if (outv > NOTE_MAX) note = NOTE_W'(NOTE_MAX);
    else note = outv[NOTE_W-1:0];

    ev.value = outv;
    ev.trig  = fresh && fires;
    ev.gate  = gate_now;
    ev.idx   = cur;
    if (gate_now && !m_last_gate) begin
      if (m_holding) begin
        ev.kind = MIDI_OFF;
        ev.note = m_held_note;
        ev.last = 1'b0;
        expected_events = {expected_events, ev};
      end
      ev.kind = MIDI_ON;
      ev.note = note;
      ev.last = 1'b1;
      expected_events = {expected_events, ev};
      m_held_note = note;
      m_holding   = 1'b1;
    end else if (!gate_now && m_last_gate && m_holding) begin
      ev.kind = MIDI_OFF;
      ev.note = m_held_note;
      ev.last = 1'b1;
      expected_events = {expected_events, ev};
      m_holding = 1'b0;
    end else begin
      ev.kind = MIDI_NONE;
      ev.note = '0;
      ev.last = 1'b1;
      expected_events = {expected_events, ev};
    end
    m_last_gate = gate_now;
  endfunction

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input logic op, input logic [PB-1:0] phase,
                           input logic [LOAD_IDX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.tick_phase <= phase;
    in_bus.load_index <= idx;
    in_bus.load_value <= val;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (op == OP_LOAD) begin
      m_table[idx] = val;
      load_count++;
    end else begin
      predict_tick(phase);
      tick_count++;
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    int v;
    case ($urandom_range(11))
      0:       v = -VALUE_LIMIT;
      1:       v = VALUE_LIMIT;
      2:       v = NOTE_MAX + 1;
      default: v = int'($urandom_range(2 * VALUE_LIMIT)) - VALUE_LIMIT;
    endcase
    return VALUE_W'(v);
  endfunction

  task automatic send_tick(input logic [PB-1:0] phase);
    send_item(OP_TICK, phase, LOAD_IDX_W'($urandom), random_value());
  endtask

  task automatic send_load(input logic [LOAD_IDX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val);
    send_item(OP_LOAD, PB'($urandom), idx, val);
  endtask

  // Walk the phase forward mostly, with some back steps and jumps
  function automatic logic [PB-1:0] next_phase();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) walk_phase = PB'(walk_phase + $urandom_range(1, walk_stride));
    else if (pick < 88) walk_phase = PB'(walk_phase - $urandom_range(1, HALF_BEAT));
    else if (pick < 95) walk_phase = PB'($urandom);
    return walk_phase;
  endfunction

  // Drop valid and drain every pending result before touching registers
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (r)
      REG_STEP_COUNT:  m_step_count = v[SC_W-1:0];
      REG_RATE_SELECT: m_rate       = v[RS_W-1:0];
      REG_GATE_LENGTH: m_gate_len   = v[GL_W-1:0];
      REG_FIRE_PROB:   m_fire_prob  = v[FP_W-1:0];
      REG_MIDI_CHAN:   m_chan       = v[CH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [SC_W-1:0] sc, input logic [RS_W-1:0] rs,
                               input logic [GL_W-1:0] gl, input logic [FP_W-1:0] fp,
                               input logic [CH_W-1:0] ch);
    wait_idle();
    cfg_write(REG_STEP_COUNT, PDATA_W'(sc));
    cfg_write(REG_RATE_SELECT, PDATA_W'(rs));
    cfg_write(REG_GATE_LENGTH, PDATA_W'(gl));
    cfg_write(REG_FIRE_PROB, PDATA_W'(fp));
    cfg_write(REG_MIDI_CHAN, PDATA_W'(ch));
    setting_count++;
  endtask

  // Fill every table entry first so no tick ever reads an unwritten one
  task automatic test_load_table();
    for (int i = 0; i < STEPS; i++) begin
      case (i)
        0:       send_load(LOAD_IDX_W'(i), VALUE_W'(-VALUE_LIMIT));
        1:       send_load(LOAD_IDX_W'(i), VALUE_W'(VALUE_LIMIT));
        2:       send_load(LOAD_IDX_W'(i), VALUE_W'(NOTE_MAX));
        3:       send_load(LOAD_IDX_W'(i), VALUE_W'(NOTE_MAX + 1));
        4:       send_load(LOAD_IDX_W'(i), VALUE_W'(-1));
        5:       send_load(LOAD_IDX_W'(i), '0);
        default: send_load(LOAD_IDX_W'(i), random_value());
      endcase
    end
  endtask

  // Reset settings: gate edge around the default length, full and half-beat drops
  task automatic test_phase_edges();
    send_tick(16'h0000);
    send_tick(16'hCCCC);
    send_tick(16'hCCCD);
    send_tick(16'hFFFF);
    send_tick(16'h0000);
    send_tick(16'h8000);
    send_tick(16'h0000);
    send_tick(16'h8001);
    send_tick(16'h0000);
  endtask

  // Global step zero under a fractional probability, then never firing
  task automatic test_zero_seed();
    wait_idle();
    cfg_write(REG_RATE_SELECT, PDATA_W'(RATE_QUARTER));
    cfg_write(REG_FIRE_PROB, 32'd40000);
    send_tick(16'h0064);
    send_tick(16'h2000);
    wait_idle();
    cfg_write(REG_FIRE_PROB, '0);
    send_tick(16'h4000);
    walk_phase = 16'h4000;
  endtask

  // One register setting per pass with a burst of ticks and loads under it
  task automatic test_random_traffic(input int first, input int last_set);
    for (int k = first; k <= last_set; k++) begin
      case (k)
        0: apply_setting(5'd1, RATE_QUARTER, GATE_MIN, '0, 4'hF);
        1: apply_setting(5'd16, RATE_OVER, Q16_TOP, Q16_TOP, 4'h0);
        2: apply_setting(5'd0, RATE_EIGHT, GATE_ONE, PROB_ONE - 1'b1, 4'h5);
        3: apply_setting(5'd31, RATE_SIX, GATE_ONE - 1'b1, 17'd1, 4'hA);
        default: begin
          apply_setting(SC_W'(($urandom_range(99) < 80) ? $urandom_range(1, STEPS) : $urandom),
                        RS_W'(($urandom_range(99) < 85) ? $urandom_range(8) : $urandom),
                        GL_W'(($urandom_range(99) < 85) ? $urandom_range(655, 65536)
                                                        : $urandom),
                        FP_W'(($urandom_range(99) < 60) ? $urandom_range(65535) :
                          (($urandom_range(1) == 0) ? PROB_ONE : $urandom)),
                        CH_W'($urandom));
        end
      endcase
      walk_stride = $urandom_range(1500, 30000);
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if ($urandom_range(99) < 9) send_load(LOAD_IDX_W'($urandom), random_value());
        else send_tick(next_phase());
      end
    end
  endtask

  // Hold the result side off while ticks keep coming, so the input backs up
  task automatic test_result_stall();
    wait_idle();
    stall_request = STALL_CYCLES;
    for (int i = 0; i < 40; i++) send_tick(next_phase());
  endtask

  // Check each accepted result against the oldest prediction; drive ready
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got_ev.value = out_bus.step_value_out;
      got_ev.trig  = out_bus.trigger;
      got_ev.gate  = out_bus.gate;
      got_ev.idx   = out_bus.step_index;
      got_ev.kind  = midi_kind_t'(out_bus.midi_kind);
      got_ev.note  = out_bus.midi_note;
      got_ev.last  = out_bus.last;
      result_count++;
      if (expected_events.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result item with nothing expected: value %0d step %0d kind %0d",
                   $time, got_ev.value, got_ev.idx, got_ev.kind);
        mismatch_count++;
      end else begin
        want_ev = expected_events.pop_front();
        if (got_ev.value !== want_ev.value || got_ev.trig !== want_ev.trig ||
            got_ev.gate !== want_ev.gate || got_ev.idx !== want_ev.idx ||
            got_ev.kind !== want_ev.kind || got_ev.note !== want_ev.note ||
            got_ev.last !== want_ev.last) begin
          if (mismatch_count < 10) begin
            $display("%0t: expected value %0d trig %b gate %b step %0d kind %0d note %0d last %b",
                     $time, want_ev.value, want_ev.trig, want_ev.gate, want_ev.idx,
                     want_ev.kind, want_ev.note, want_ev.last);
            $display("%0t:   actual value %0d trig %b gate %b step %0d kind %0d note %0d last %b",
                     $time, got_ev.value, got_ev.trig, got_ev.gate, got_ev.idx,
                     got_ev.kind, got_ev.note, got_ev.last);
          end
          mismatch_count++;
        end
      end
    end
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_bus.valid      = 1'b0;
    in_bus.op         = OP_TICK;
    in_bus.tick_phase = '0;
    in_bus.load_index = '0;
    in_bus.load_value = '0;
    out_bus.ready     = 1'b0;
    m_step_count      = RST_STEP_COUNT;
    m_rate            = RST_RATE_SELECT;
    m_gate_len        = RST_GATE_LENGTH;
    m_fire_prob       = RST_FIRE_PROB;
    m_chan            = RST_MIDI_CHAN;
    m_last_phase      = '0;
    m_beats           = '0;
    m_last_step       = '0;
    m_step_seen       = 1'b0;
    m_last_gate       = 1'b0;
    m_held_note       = '0;
    m_holding         = 1'b0;
    for (int i = 0; i < STEPS; i++) m_table[i] = '0;
    src_idle_pct      = 10;
    snk_idle_pct      = 46;
    stall_request     = 0;
    stall_left        = 0;
    mismatch_count    = 0;
    tick_count        = 0;
    load_count        = 0;
    result_count      = 0;
    setting_count     = 0;
    walk_phase        = '0;
    walk_stride       = 4000;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_table();
    test_phase_edges();
    test_zero_seed();
    test_random_traffic(0, 4);
    src_idle_pct = 46;
    snk_idle_pct = 10;
    test_random_traffic(5, 9);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(10, NUM_SETS - 1);
    test_result_stall();
    wait_idle();

    $display("covered %0d ticks and %0d table loads under %0d register settings, %0d results",
             tick_count, load_count, setting_count, result_count);
    $display("with beat-wrap boundaries, zero seed, out-of-range codes and a %0d-cycle stall",
             STALL_CYCLES);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pss_pkg.sv
rtl/pss_in_if.sv
rtl/pss_out_if.sv
rtl/pss_ram.sv
rtl/pss_rem.sv
rtl/probabilistic_step_sequencer.sv
test/tb_probabilistic_step_sequencer.sv
